/* src/lmr_pkg.sv */
`default_nettype none

package lmr_pkg;

  localparam int NUM_COLS    = 72;
  localparam int NUM_ROWS    = 7;
  localparam int LAST_COL    = 71;
  localparam int NUM_BYTES   = 9;
  localparam int FONT_BYTES  = 191;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_DRAW  = 2'd1;
  localparam logic [1:0] MODE_SCAN  = 2'd2;

  typedef logic [1:0] mode_t;

  typedef struct packed {
    logic [2:0] width;
    logic [7:0] start;
  } glyph_info_t;

  typedef struct packed {
    mode_t       mode;
    logic        first_char;
    glyph_info_t glyph;
    logic [15:0] start_column;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } push_t;

  localparam logic [7:0] GLYPH_ROM [FONT_BYTES] = '{
    8'h5f,8'h1c,8'h22,8'h41,8'h41,8'h22,8'h1c,8'h40,8'h60,8'h1c,
    8'h03,8'h3e,8'h41,8'h41,8'h41,8'h3e,8'h02,8'h7f,8'h62,8'h51,
    8'h49,8'h46,8'h22,8'h49,8'h49,8'h36,8'h0f,8'h08,8'h08,8'h7f,
    8'h2f,8'h49,8'h49,8'h39,8'h3e,8'h49,8'h49,8'h32,8'h01,8'h61,
    8'h19,8'h07,8'h36,8'h49,8'h49,8'h36,8'h26,8'h49,8'h49,8'h3e,
    8'h12,8'h20,8'h12,8'h02,8'h59,8'h09,8'h06,8'h3e,8'h41,8'h5d,
    8'h55,8'h4e,8'h20,8'h7e,8'h09,8'h09,8'h09,8'h7e,8'h7f,8'h49,
    8'h49,8'h36,8'h3e,8'h41,8'h41,8'h41,8'h22,8'h7f,8'h41,8'h41,
    8'h3e,8'h7f,8'h49,8'h49,8'h41,8'h7f,8'h09,8'h09,8'h01,8'h3e,
    8'h41,8'h41,8'h49,8'h3a,8'h7f,8'h08,8'h08,8'h08,8'h7f,8'h41,
    8'h7f,8'h41,8'h20,8'h40,8'h40,8'h3f,8'h7f,8'h08,8'h14,8'h23,
    8'h40,8'h7f,8'h40,8'h40,8'h40,8'h7f,8'h02,8'h04,8'h08,8'h04,
    8'h02,8'h7f,8'h7f,8'h02,8'h04,8'h08,8'h10,8'h7f,8'h3e,8'h41,
    8'h41,8'h41,8'h41,8'h3e,8'h7f,8'h09,8'h09,8'h09,8'h06,8'h3e,
    8'h41,8'h51,8'h21,8'h5e,8'h7f,8'h09,8'h19,8'h66,8'h26,8'h49,
    8'h49,8'h32,8'h01,8'h01,8'h7f,8'h01,8'h01,8'h3f,8'h40,8'h40,
    8'h40,8'h3f,8'h1f,8'h20,8'h40,8'h20,8'h1f,8'h7f,8'h20,8'h10,
    8'h08,8'h10,8'h20,8'h7f,8'h41,8'h22,8'h14,8'h08,8'h14,8'h22,
    8'h41,8'h07,8'h08,8'h78,8'h08,8'h07,8'h61,8'h51,8'h49,8'h45,
    8'h43
  };

  function automatic logic [6:0] glyph_byte_f(input logic [7:0] addr);
    logic [6:0] data;
    data = '0;
    if (int'(addr) < FONT_BYTES) begin
      data = GLYPH_ROM[addr][6:0];
    end
    return data;
  endfunction

  function automatic glyph_info_t glyph_info_f(input logic [7:0] code);
    glyph_info_t g;
    g = '0;
    case (code)
      8'd33: g = '{3'd1, 8'd0};
      8'd40: g = '{3'd3, 8'd1};
      8'd41: g = '{3'd3, 8'd4};
      8'd46: g = '{3'd1, 8'd7};
      8'd47: g = '{3'd3, 8'd8};
      8'd48: g = '{3'd5, 8'd11};
      8'd49: g = '{3'd2, 8'd16};
      8'd50: g = '{3'd4, 8'd18};
      8'd51: g = '{3'd4, 8'd22};
      8'd52: g = '{3'd4, 8'd26};
      8'd53: g = '{3'd4, 8'd30};
      8'd54: g = '{3'd4, 8'd34};
      8'd55: g = '{3'd4, 8'd38};
      8'd56: g = '{3'd4, 8'd42};
      8'd57: g = '{3'd4, 8'd46};
      8'd58: g = '{3'd1, 8'd50};
      8'd59: g = '{3'd2, 8'd51};
      8'd63: g = '{3'd4, 8'd53};
      8'd64: g = '{3'd6, 8'd57};
      8'd65: g = '{3'd5, 8'd63};
      8'd66: g = '{3'd4, 8'd68};
      8'd67: g = '{3'd5, 8'd72};
      8'd68: g = '{3'd4, 8'd77};
      8'd69: g = '{3'd4, 8'd81};
      8'd70: g = '{3'd4, 8'd85};
      8'd71: g = '{3'd5, 8'd89};
      8'd72: g = '{3'd5, 8'd94};
      8'd73: g = '{3'd3, 8'd99};
      8'd74: g = '{3'd4, 8'd102};
      8'd75: g = '{3'd5, 8'd106};
      8'd76: g = '{3'd4, 8'd111};
      8'd77: g = '{3'd7, 8'd115};
      8'd78: g = '{3'd6, 8'd122};
      8'd79: g = '{3'd6, 8'd128};
      8'd80: g = '{3'd5, 8'd134};
      8'd81: g = '{3'd5, 8'd139};
      8'd82: g = '{3'd4, 8'd144};
      8'd83: g = '{3'd4, 8'd148};
      8'd84: g = '{3'd5, 8'd152};
      8'd85: g = '{3'd5, 8'd157};
      8'd86: g = '{3'd5, 8'd162};
      8'd87: g = '{3'd7, 8'd167};
      8'd88: g = '{3'd7, 8'd174};
      8'd89: g = '{3'd5, 8'd181};
      8'd90: g = '{3'd5, 8'd186};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

/* src/lmr_front.sv */
`default_nettype none

module lmr_front (
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_mode,
  input  wire logic [7:0]         in_char_code,
  input  wire logic               in_first_char,
  input  wire logic signed [15:0] in_start_column,
  input  wire logic               q_ready,
  output lmr_pkg::push_t          push
);

  logic known_mode;

  assign known_mode = (in_mode == lmr_pkg::MODE_CLEAR) ||
                      (in_mode == lmr_pkg::MODE_DRAW)  ||
                      (in_mode == lmr_pkg::MODE_SCAN);

  assign in_ready = q_ready;

  always_comb begin
    push.valid              = in_valid && q_ready && known_mode;
    push.entry.mode         = in_mode;
    push.entry.first_char   = in_first_char;
    push.entry.glyph        = lmr_pkg::glyph_info_f(in_char_code);
    push.entry.start_column = $unsigned(in_start_column);
  end

endmodule

`default_nettype wire

/* src/lmr_queue.sv */
`default_nettype none

module lmr_queue #(
  parameter int DEPTH = lmr_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire lmr_pkg::push_t  push,
  output logic                 push_ready,
  output logic                 pop_valid,
  output lmr_pkg::q_entry_t    pop_entry,
  input  wire logic            pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lmr_pkg::q_entry_t entries_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [CW-1:0]     count_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = entries_r[rd_ptr_r];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count exceeds depth");
`endif

endmodule

`default_nettype wire

/* src/lmr_back.sv */
`default_nettype none

module lmr_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire lmr_pkg::q_entry_t  q_entry,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_row_index,
  output logic [7:0]              out_row_select,
  output logic [lmr_pkg::NUM_BYTES-1:0][7:0] out_bytes,
  output logic                    out_last_row
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DRAW = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]  state_r;
  logic [15:0] cursor_r;
  logic [2:0]  cnt_r;
  logic [2:0]  width_r;
  logic [7:0]  base_r;
  logic [2:0]  row_r;
  logic [lmr_pkg::NUM_COLS-1:0] frame_rows_r [lmr_pkg::NUM_ROWS];

  logic [7:0]  rom_addr;
  logic [6:0]  glyph_col;
  logic        in_view;
  logic        out_load;

  logic        out_valid_r;
  logic [2:0]  row_index_r;
  logic [7:0]  row_select_r;
  logic [lmr_pkg::NUM_BYTES-1:0][7:0] bytes_r;
  logic        last_row_r;

  assign q_pop     = q_valid && (state_r == ST_IDLE);
  assign rom_addr  = base_r + {5'b0, cnt_r};
  assign glyph_col = lmr_pkg::glyph_byte_f(rom_addr);
  assign in_view   = (cursor_r <= 16'(lmr_pkg::LAST_COL));
  assign out_load  = (state_r == ST_SCAN) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cursor_r     <= '0;
      frame_rows_r <= '{default: '0};
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_entry.mode == lmr_pkg::MODE_CLEAR) begin
              frame_rows_r <= '{default: '0};
            end else if (q_entry.mode == lmr_pkg::MODE_DRAW) begin
              if (q_entry.first_char) begin
                cursor_r <= q_entry.start_column;
              end
              cnt_r   <= '0;
              width_r <= q_entry.glyph.width;
              base_r  <= q_entry.glyph.start;
              state_r <= ST_DRAW;
            end else begin
              row_r   <= '0;
              state_r <= ST_SCAN;
            end
          end
        end
        ST_DRAW: begin
          cursor_r <= cursor_r + 16'd1;
          if (cnt_r < width_r) begin
            if (in_view) begin
              for (int y = 0; y < lmr_pkg::NUM_ROWS; y++) begin
                frame_rows_r[y][cursor_r[6:0]] <= glyph_col[y];
              end
            end
            cnt_r <= cnt_r + 3'd1;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (out_load) begin
            row_r <= row_r + 3'd1;
            if (row_r == 3'(lmr_pkg::NUM_ROWS - 1)) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      row_index_r  <= row_r;
      row_select_r <= ~(8'h80 >> row_r);
      last_row_r   <= (row_r == 3'(lmr_pkg::NUM_ROWS - 1));
      for (int k = 0; k < lmr_pkg::NUM_BYTES; k++) begin
        bytes_r[k] <= ~frame_rows_r[row_r][8*k +: 8];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row_index  = row_index_r;
  assign out_row_select = row_select_r;
  assign out_bytes      = bytes_r;
  assign out_last_row   = last_row_r;

`ifndef SYNTHESIS
  a_draw_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAW) |-> (cnt_r <= width_r))
    else $error("glyph column count passed the glyph width");

  a_scan_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (row_r < 3'(lmr_pkg::NUM_ROWS)))
    else $error("scan row out of range");

  a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && (q_entry.mode == lmr_pkg::MODE_SCAN)) |=>
      ((state_r == ST_SCAN) && (row_r == 3'd0)))
    else $error("scan did not start at row zero");
`endif

endmodule

`default_nettype wire

/* src/led_text_marquee_renderer_core.sv */
// A clear is done from the idle state; a character is drawn column by column, with the cursor
// moving one column past the glyph as a gap; a scan starts, then reads out each row in turn,
// each row load waiting until the output register is empty or being taken.
// A scan request passes through the queue and the scan state before its first row is loaded into the output registers.
// A two-entry queue decouples input transfers from the drawing and scan sequencer.
// Reset (rst_n low, synchronous) clears the frame buffer, the cursor, the queue and out_valid.
`default_nettype none

module led_text_marquee_renderer_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_mode,
  input  wire logic [7:0]         in_char_code,
  input  wire logic               in_first_char,
  input  wire logic signed [15:0] in_start_column,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_row_index,
  output logic [7:0]              out_row_select,
  output logic [7:0]              out_shift_byte_0,
  output logic [7:0]              out_shift_byte_1,
  output logic [7:0]              out_shift_byte_2,
  output logic [7:0]              out_shift_byte_3,
  output logic [7:0]              out_shift_byte_4,
  output logic [7:0]              out_shift_byte_5,
  output logic [7:0]              out_shift_byte_6,
  output logic [7:0]              out_shift_byte_7,
  output logic [7:0]              out_shift_byte_8,
  output logic                    out_last_row
);

  lmr_pkg::push_t    push;
  logic              q_ready;
  logic              q_valid;
  lmr_pkg::q_entry_t q_entry;
  logic              q_pop;
  logic [lmr_pkg::NUM_BYTES-1:0][7:0] out_bytes;

  lmr_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_char_code    (in_char_code),
    .in_first_char   (in_first_char),
    .in_start_column (in_start_column),
    .q_ready         (q_ready),
    .push            (push)
  );

  lmr_queue #(
    .DEPTH (lmr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (q_ready),
    .pop_valid  (q_valid),
    .pop_entry  (q_entry),
    .pop        (q_pop)
  );

  lmr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_entry        (q_entry),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row_index  (out_row_index),
    .out_row_select (out_row_select),
    .out_bytes      (out_bytes),
    .out_last_row   (out_last_row)
  );

  assign out_shift_byte_0 = out_bytes[0];
  assign out_shift_byte_1 = out_bytes[1];
  assign out_shift_byte_2 = out_bytes[2];
  assign out_shift_byte_3 = out_bytes[3];
  assign out_shift_byte_4 = out_bytes[4];
  assign out_shift_byte_5 = out_bytes[5];
  assign out_shift_byte_6 = out_bytes[6];
  assign out_shift_byte_7 = out_bytes[7];
  assign out_shift_byte_8 = out_bytes[8];

endmodule

`default_nettype wire

/* sim/led_text_marquee_renderer_core_test.sv */
`timescale 1ns / 1ps

module led_text_marquee_renderer_core_test;

  localparam lmr_pkg::mode_t MODE_UNUSED  = 2'd3;
  localparam int             RANDOM_ITEMS = 245;
  localparam int             CALM_TAIL    = 40;
  localparam int             DRAIN_CYCLES = 20;
  localparam int             QUIET_LIMIT  = 4000;

  typedef struct packed {
    logic [2:0]      row_index;
    logic [7:0]      row_select;
    logic [8:0][7:0] shift;
    logic            last_row;
  } row_result_t;

  typedef struct packed {
    lmr_pkg::mode_t mode;
    logic [7:0]     code;
    logic           first;
    logic [15:0]    start;
    logic           blank;
  } stim_row_t;

  localparam logic [7:0] BLANK_ROW_SELECT [7] = '{
    8'h7F, 8'hBF, 8'hDF, 8'hEF, 8'hF7, 8'hFB, 8'hFD
  };

  localparam logic [7:0] FONT_COLUMNS [191] = '{
    8'h5f,8'h1c,8'h22,8'h41,8'h41,8'h22,8'h1c,8'h40,8'h60,8'h1c,
    8'h03,8'h3e,8'h41,8'h41,8'h41,8'h3e,8'h02,8'h7f,8'h62,8'h51,
    8'h49,8'h46,8'h22,8'h49,8'h49,8'h36,8'h0f,8'h08,8'h08,8'h7f,
    8'h2f,8'h49,8'h49,8'h39,8'h3e,8'h49,8'h49,8'h32,8'h01,8'h61,
    8'h19,8'h07,8'h36,8'h49,8'h49,8'h36,8'h26,8'h49,8'h49,8'h3e,
    8'h12,8'h20,8'h12,8'h02,8'h59,8'h09,8'h06,8'h3e,8'h41,8'h5d,
    8'h55,8'h4e,8'h20,8'h7e,8'h09,8'h09,8'h09,8'h7e,8'h7f,8'h49,
    8'h49,8'h36,8'h3e,8'h41,8'h41,8'h41,8'h22,8'h7f,8'h41,8'h41,
    8'h3e,8'h7f,8'h49,8'h49,8'h41,8'h7f,8'h09,8'h09,8'h01,8'h3e,
    8'h41,8'h41,8'h49,8'h3a,8'h7f,8'h08,8'h08,8'h08,8'h7f,8'h41,
    8'h7f,8'h41,8'h20,8'h40,8'h40,8'h3f,8'h7f,8'h08,8'h14,8'h23,
    8'h40,8'h7f,8'h40,8'h40,8'h40,8'h7f,8'h02,8'h04,8'h08,8'h04,
    8'h02,8'h7f,8'h7f,8'h02,8'h04,8'h08,8'h10,8'h7f,8'h3e,8'h41,
    8'h41,8'h41,8'h41,8'h3e,8'h7f,8'h09,8'h09,8'h09,8'h06,8'h3e,
    8'h41,8'h51,8'h21,8'h5e,8'h7f,8'h09,8'h19,8'h66,8'h26,8'h49,
    8'h49,8'h32,8'h01,8'h01,8'h7f,8'h01,8'h01,8'h3f,8'h40,8'h40,
    8'h40,8'h3f,8'h1f,8'h20,8'h40,8'h20,8'h1f,8'h7f,8'h20,8'h10,
    8'h08,8'h10,8'h20,8'h7f,8'h41,8'h22,8'h14,8'h08,8'h14,8'h22,
    8'h41,8'h07,8'h08,8'h78,8'h08,8'h07,8'h61,8'h51,8'h49,8'h45,
    8'h43
  };

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_mode;
  logic [7:0]         in_char_code;
  logic               in_first_char;
  logic [15:0]        in_start_column;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         out_row_index;
  logic [7:0]         out_row_select;
  logic [7:0]         out_shift_byte_0;
  logic [7:0]         out_shift_byte_1;
  logic [7:0]         out_shift_byte_2;
  logic [7:0]         out_shift_byte_3;
  logic [7:0]         out_shift_byte_4;
  logic [7:0]         out_shift_byte_5;
  logic [7:0]         out_shift_byte_6;
  logic [7:0]         out_shift_byte_7;
  logic [7:0]         out_shift_byte_8;
  logic               out_last_row;

  logic [6:0]         frame_cols [lmr_pkg::NUM_COLS];
  logic [15:0]        cursor_col;
  row_result_t        pending_rows [$];
  int                 errors = 0;
  int                 quiet_cycles = 0;
  bit                 calm = 1'b0;

  stim_row_t directed_rows [22] = '{
    {lmr_pkg::MODE_SCAN,  8'd0,   1'b0, 16'h0000, 1'b1},
    {lmr_pkg::MODE_DRAW,  8'd77,  1'b0, 16'h0000, 1'b0},
    {lmr_pkg::MODE_DRAW,  8'd87,  1'b0, 16'hFFFF, 1'b0},
    {lmr_pkg::MODE_DRAW,  8'd255, 1'b0, 16'h0000, 1'b0},
    {lmr_pkg::MODE_DRAW,  8'd0,   1'b0, 16'h0000, 1'b0},
    {lmr_pkg::MODE_DRAW,  8'd33,  1'b0, 16'h0000, 1'b0},
    {lmr_pkg::MODE_DRAW,  8'd90,  1'b0, 16'h0000, 1'b0},
    {lmr_pkg::MODE_DRAW,  8'd127, 1'b0, 16'h0000, 1'b0},
    {lmr_pkg::MODE_DRAW,  8'd128, 1'b0, 16'h0000, 1'b0},
    {MODE_UNUSED,         8'hAA,  1'b1, 16'h5555, 1'b0},
    {lmr_pkg::MODE_SCAN,  8'hFF,  1'b1, 16'hFFFF, 1'b0},
    {lmr_pkg::MODE_CLEAR, 8'hFF,  1'b1, 16'hFFFF, 1'b0},
    {lmr_pkg::MODE_SCAN,  8'd0,   1'b0, 16'h0000, 1'b1},
    {lmr_pkg::MODE_DRAW,  8'd64,  1'b1, 16'hFFFD, 1'b0},
    {lmr_pkg::MODE_DRAW,  8'd88,  1'b1, 16'd68,   1'b0},
    {lmr_pkg::MODE_DRAW,  8'd77,  1'b1, 16'd71,   1'b0},
    {lmr_pkg::MODE_DRAW,  8'd65,  1'b1, 16'h7FFF, 1'b0},
    {lmr_pkg::MODE_DRAW,  8'd65,  1'b1, 16'h8000, 1'b0},
    {lmr_pkg::MODE_DRAW,  8'd77,  1'b1, 16'hFFFE, 1'b0},
    {lmr_pkg::MODE_SCAN,  8'd0,   1'b0, 16'h0000, 1'b0},
    {lmr_pkg::MODE_DRAW,  8'd48,  1'b1, 16'd72,   1'b0},
    {lmr_pkg::MODE_SCAN,  8'd0,   1'b0, 16'h0000, 1'b0}
  };

  led_text_marquee_renderer_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_char_code     (in_char_code),
    .in_first_char    (in_first_char),
    .in_start_column  (in_start_column),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_row_index    (out_row_index),
    .out_row_select   (out_row_select),
    .out_shift_byte_0 (out_shift_byte_0),
    .out_shift_byte_1 (out_shift_byte_1),
    .out_shift_byte_2 (out_shift_byte_2),
    .out_shift_byte_3 (out_shift_byte_3),
    .out_shift_byte_4 (out_shift_byte_4),
    .out_shift_byte_5 (out_shift_byte_5),
    .out_shift_byte_6 (out_shift_byte_6),
    .out_shift_byte_7 (out_shift_byte_7),
    .out_shift_byte_8 (out_shift_byte_8),
    .out_last_row     (out_last_row)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Width in the top three bits, first font column address in the low byte.
  function automatic logic [10:0] glyph_entry(input logic [7:0] code);
    case (code)
      8'd33: return {3'd1, 8'd0};    8'd40: return {3'd3, 8'd1};
      8'd41: return {3'd3, 8'd4};    8'd46: return {3'd1, 8'd7};
      8'd47: return {3'd3, 8'd8};    8'd48: return {3'd5, 8'd11};
      8'd49: return {3'd2, 8'd16};   8'd50: return {3'd4, 8'd18};
      8'd51: return {3'd4, 8'd22};   8'd52: return {3'd4, 8'd26};
      8'd53: return {3'd4, 8'd30};   8'd54: return {3'd4, 8'd34};
      8'd55: return {3'd4, 8'd38};   8'd56: return {3'd4, 8'd42};
      8'd57: return {3'd4, 8'd46};   8'd58: return {3'd1, 8'd50};
      8'd59: return {3'd2, 8'd51};   8'd63: return {3'd4, 8'd53};
      8'd64: return {3'd6, 8'd57};   8'd65: return {3'd5, 8'd63};
      8'd66: return {3'd4, 8'd68};   8'd67: return {3'd5, 8'd72};
      8'd68: return {3'd4, 8'd77};   8'd69: return {3'd4, 8'd81};
      8'd70: return {3'd4, 8'd85};   8'd71: return {3'd5, 8'd89};
      8'd72: return {3'd5, 8'd94};   8'd73: return {3'd3, 8'd99};
      8'd74: return {3'd4, 8'd102};  8'd75: return {3'd5, 8'd106};
      8'd76: return {3'd4, 8'd111};  8'd77: return {3'd7, 8'd115};
      8'd78: return {3'd6, 8'd122};  8'd79: return {3'd6, 8'd128};
      8'd80: return {3'd5, 8'd134};  8'd81: return {3'd5, 8'd139};
      8'd82: return {3'd4, 8'd144};  8'd83: return {3'd4, 8'd148};
      8'd84: return {3'd5, 8'd152};  8'd85: return {3'd5, 8'd157};
      8'd86: return {3'd5, 8'd162};  8'd87: return {3'd7, 8'd167};
      8'd88: return {3'd7, 8'd174};  8'd89: return {3'd5, 8'd181};
      8'd90: return {3'd5, 8'd186};
      default: return 11'd0;
    endcase
  endfunction

  function automatic void draw_glyph(input logic [7:0] code);
    logic [10:0] g;
    int          addr;
    g = glyph_entry(code);
    for (int i = 0; i < int'(g[10:8]); i++) begin
      addr = int'(g[7:0]) + i;
      if (cursor_col <= 16'(lmr_pkg::LAST_COL)) begin
        frame_cols[cursor_col] = (addr < lmr_pkg::FONT_BYTES) ? FONT_COLUMNS[addr][6:0]
                                                               : 7'd0;
      end
      cursor_col = cursor_col + 16'd1;
    end
    cursor_col = cursor_col + 16'd1;
  endfunction

  function automatic void render_item(input lmr_pkg::mode_t mode, input logic [7:0] code,
                                      input logic first, input logic [15:0] start,
                                      input logic blank);
    row_result_t r;
    case (mode)
      lmr_pkg::MODE_CLEAR: begin
        foreach (frame_cols[i]) frame_cols[i] = 7'd0;
      end
      lmr_pkg::MODE_DRAW: begin
        if (first) cursor_col = start;
        draw_glyph(code);
      end
      lmr_pkg::MODE_SCAN: begin
        for (int y = 0; y < lmr_pkg::NUM_ROWS; y++) begin
          if (blank) begin
            r = {3'(y), BLANK_ROW_SELECT[y], {9{8'hFF}}, (y == 6)};
          end else begin
            r.row_index  = 3'(y);
            r.row_select = 8'hFF & ~(8'h01 << (7 - y));
            for (int k = 0; k < lmr_pkg::NUM_BYTES; k++) begin
              for (int n = 0; n < 8; n++) r.shift[k][n] = ~frame_cols[k * 8 + n][y];
            end
            r.last_row = (y == lmr_pkg::NUM_ROWS - 1);
          end
          pending_rows.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input lmr_pkg::mode_t mode, input logic [7:0] code,
                           input logic first, input logic [15:0] start, input logic blank);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_char_code    <= code;
    in_first_char   <= first;
    in_start_column <= start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    render_item(mode, code, first, start, blank);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_rows.size() != 0) @(negedge clk);
  endtask

  function automatic void compare_field(input string what, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %h got %h", $time, what, want, got);
    end
  endfunction

  initial begin : receiver
    int hold;
    hold = 0;
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        hold = $urandom_range(1, 12) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : row_monitor
    row_result_t want;
    row_result_t seen;
    if (rst_n && out_valid && out_ready) begin
      seen = {out_row_index, out_row_select,
              out_shift_byte_8, out_shift_byte_7, out_shift_byte_6,
              out_shift_byte_5, out_shift_byte_4, out_shift_byte_3,
              out_shift_byte_2, out_shift_byte_1, out_shift_byte_0, out_last_row};
      if (pending_rows.size() == 0) begin
        errors++;
        $display("%0t: row transfer with none expected, row_index %0d", $time,
                 out_row_index);
      end else begin
        want = pending_rows.pop_front();
        compare_field("row_index", 8'(want.row_index), 8'(seen.row_index));
        compare_field("row_select", want.row_select, seen.row_select);
        for (int k = 0; k < lmr_pkg::NUM_BYTES; k++) begin
          compare_field($sformatf("shift_byte_%0d", k), want.shift[k], seen.shift[k]);
        end
        compare_field("last_row", 8'(want.last_row), 8'(seen.last_row));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    int          count;
    int          kind;
    int          len;
    bit          paused;
    logic [15:0] s;
    logic [7:0]  c;
    logic [1:0]  m;
    count  = 0;
    paused = 1'b0;
    foreach (frame_cols[i]) frame_cols[i] = 7'd0;
    cursor_col = 16'd0;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_mode         <= lmr_pkg::MODE_CLEAR;
    in_char_code    <= 8'd0;
    in_first_char   <= 1'b0;
    in_start_column <= 16'd0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].mode, directed_rows[i].code, directed_rows[i].first,
                directed_rows[i].start, directed_rows[i].blank);
    end
    wait_drained();

    while (count < RANDOM_ITEMS) begin
      calm = (count >= RANDOM_ITEMS - CALM_TAIL) || (((count / 30) % 3) == 1);
      if (!paused && count >= RANDOM_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        len = $urandom_range(1, 8);
        case ($urandom_range(0, 9))
          0:       s = 16'($urandom_range(0, 65535));
          1:       s = 16'hFFF8 + 16'($urandom_range(0, 7));
          2:       s = 16'h7FF8 + 16'($urandom_range(0, 7));
          default: s = 16'($urandom_range(0, 80)) - 16'd8;
        endcase
        for (int j = 0; j < len; j++) begin
          c = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(32, 90));
          send_item(lmr_pkg::MODE_DRAW, c, (j == 0) || ($urandom_range(0, 19) == 0),
                    (j == 0) ? s : 16'($urandom_range(0, 65535)), 1'b0);
          count++;
        end
        if ($urandom_range(0, 9) < 6) begin
          send_item(lmr_pkg::MODE_SCAN, 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)), 1'b0);
          count++;
        end
      end else if (kind < 75) begin
        send_item(lmr_pkg::MODE_SCAN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  16'($urandom_range(0, 65535)), 1'b0);
        count++;
      end else if (kind < 87) begin
        send_item(lmr_pkg::MODE_CLEAR, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)), 1'b0);
        count++;
      end else if (kind < 93) begin
        send_item(MODE_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  16'($urandom_range(0, 65535)), 1'b0);
      end else begin
        m = 2'($urandom_range(0, 3));
        send_item(m, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  16'($urandom_range(0, 65535)), 1'b0);
        if (m != MODE_UNUSED) count++;
      end
    end

    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
